// ===== hdl/dks_pkg.sv =====
// Shared constants, tables and bit-selection functions for the DES key schedule.
`default_nettype none

package dks_pkg;

  localparam int KeyBits    = 64;
  localparam int HalfBits   = 28;
  localparam int CdBits     = 2 * HalfBits;
  localparam int SubkeyBits = 48;
  localparam int RoundBits  = 4;

  localparam logic [RoundBits-1:0] FIRST_ROUND = 4'd0;
  localparam logic [RoundBits-1:0] LAST_ROUND  = 4'd15;

  // Set where the round rotates by two; clear on rounds 1, 2, 9 and 16.
  localparam logic [15:0] SHIFT_TWO = 16'b0111_1110_1111_1100;

  localparam logic [6:0] PC1_TAB [CdBits] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,  7'd58, 7'd50, 7'd42, 7'd34,
    7'd26, 7'd18, 7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
    7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [6:0] PC2_TAB [SubkeyBits] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,  7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
    7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,  7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55, 7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
    7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53, 7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
  };

  typedef logic [CdBits-1:0]     cd_t;
  typedef logic [SubkeyBits-1:0] subkey_t;
  typedef logic [RoundBits-1:0]  round_t;

  typedef struct packed {
    cd_t    cd;
    round_t round;
  } rnd_word_t;

  // Key bit n (1 = MSB) sits at key[64 - n].
  function automatic cd_t pc1(input logic [KeyBits-1:0] key);
    cd_t sel;
    sel = '0;
    for (int i = 0; i < CdBits; i++) begin
      sel[CdBits-1-i] = key[6'(7'd64 - PC1_TAB[i])];
    end
    return sel;
  endfunction

  function automatic subkey_t pc2(input cd_t cd);
    subkey_t sk;
    sk = '0;
    for (int i = 0; i < SubkeyBits; i++) begin
      sk[SubkeyBits-1-i] = cd[6'(7'd56 - PC2_TAB[i])];
    end
    return sk;
  endfunction

  // Rotate both halves left by one or two.
  function automatic cd_t rotate_cd(input cd_t cd, input logic two);
    logic [HalfBits-1:0] c;
    logic [HalfBits-1:0] d;
    c = cd[CdBits-1:HalfBits];
    d = cd[HalfBits-1:0];
    if (two) begin
      return {c[HalfBits-3:0], c[HalfBits-1:HalfBits-2],
              d[HalfBits-3:0], d[HalfBits-1:HalfBits-2]};
    end
    return {c[HalfBits-2:0], c[HalfBits-1], d[HalfBits-2:0], d[HalfBits-1]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dks_pc1.sv =====
// Input register stage: captures a key and applies PC-1.
`default_nettype none

module dks_pc1 import dks_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [KeyBits-1:0]  key_in,
  output logic                     a_valid,
  output cd_t                      a_cd,
  input  wire logic                a_take
);

  logic a_valid_r;
  logic a_valid_nxt;
  cd_t  a_cd_r;
  logic in_fire;

  assign in_stall    = a_valid_r && !a_take;
  assign in_fire     = in_valid && !in_stall;
  assign a_valid_nxt = in_fire || (a_valid_r && !a_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_cd_r <= pc1(key_in);
    end
  end

  assign a_valid = a_valid_r;
  assign a_cd    = a_cd_r;

endmodule

`default_nettype wire

// ===== hdl/dks_rounds.sv =====
// Round sequencer: rotates C and D once per round and steps the round count.
`default_nettype none

module dks_rounds import dks_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      a_valid,
  input  wire cd_t       a_cd,
  output logic           a_take,
  output logic           b_valid,
  output rnd_word_t      b_word,
  input  wire logic      b_stall
);

  logic   b_valid_r;
  logic   b_valid_nxt;
  cd_t    cd_r;
  round_t round_r;
  logic   b_fire;
  logic   at_last;

  assign b_fire  = b_valid_r && !b_stall;
  assign at_last = (round_r == LAST_ROUND);
  // Take the next key once the current one has handed on its final subkey.
  assign a_take  = a_valid && (!b_valid_r || (b_fire && at_last));

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (a_take) begin
      b_valid_nxt = 1'b1;
    end else if (b_fire && at_last) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      round_r   <= FIRST_ROUND;
    end else begin
      b_valid_r <= b_valid_nxt;
      if (a_take) begin
        round_r <= FIRST_ROUND;
      end else if (b_fire && !at_last) begin
        round_r <= round_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      cd_r <= rotate_cd(a_cd, SHIFT_TWO[FIRST_ROUND]);
    end else if (b_fire && !at_last) begin
      cd_r <= rotate_cd(cd_r, SHIFT_TWO[round_r + 4'd1]);
    end
  end

  assign b_valid      = b_valid_r;
  assign b_word.cd    = cd_r;
  assign b_word.round = round_r;

  a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
    b_fire && !at_last |=> b_valid_r && round_r == $past(round_r) + 4'd1)
    else $error("round count did not advance after a non-final subkey");

  a_take_gap: assert property (@(posedge clk) disable iff (!rst_n)
    a_take |=> round_r == FIRST_ROUND && b_valid_r)
    else $error("new key did not start at the first round");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && b_stall |=> b_valid_r && $stable(round_r) && $stable(cd_r))
    else $error("round state moved under stall");

  a_no_early_take: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !at_last |-> !a_take)
    else $error("key taken before its sixteenth subkey");

endmodule

`default_nettype wire

// ===== hdl/dks_pc2.sv =====
// Output register stage: applies PC-2 and flags the final subkey.
`default_nettype none

module dks_pc2 import dks_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       b_valid,
  input  wire rnd_word_t  b_word,
  output logic            b_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output subkey_t         out_subkey,
  output round_t          out_round_index,
  output logic            out_last_subkey
);

  logic    out_valid_r;
  logic    out_valid_nxt;
  subkey_t subkey_r;
  round_t  round_r;
  logic    last_r;
  logic    load;

  assign b_stall       = out_valid_r && out_stall;
  assign load          = b_valid && !b_stall;
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      subkey_r <= pc2(b_word.cd);
      round_r  <= b_word.round;
      last_r   <= (b_word.round == LAST_ROUND);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_subkey      = subkey_r;
  assign out_round_index = round_r;
  assign out_last_subkey = last_r;

endmodule

`default_nettype wire

// ===== hdl/des_key_schedule.sv =====
// Top level of the DES key schedule: PC-1 stage, round sequencer, PC-2 stage.
//
//   channel   direction  word                                handshake
//   in_       input      key_in[63:0]                        in_valid / in_stall
//   out_      output     subkey[47:0], round_index, last     out_valid / out_stall
//
// Each key yields sixteen subkeys, one per cycle when out_stall is low; the round
// sequencer takes the next key as the final subkey of the current one is handed on.
// A key passes through the PC-1, round and PC-2 registers in turn to its first subkey.
// The next key waits in the PC-1 register while the current one is expanded.
// Reset (rst_n low, synchronous) empties all stages; stalls hold every stage intact.
`default_nettype none

module des_key_schedule import dks_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [KeyBits-1:0]  in_key_in,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output subkey_t                  out_subkey,
  output round_t                   out_round_index,
  output logic                     out_last_subkey
);

  logic      a_valid;
  cd_t       a_cd;
  logic      a_take;
  logic      b_valid;
  rnd_word_t b_word;
  logic      b_stall;

  dks_pc1 u_pc1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .key_in   (in_key_in),
    .a_valid  (a_valid),
    .a_cd     (a_cd),
    .a_take   (a_take)
  );

  dks_rounds u_rounds (
    .clk     (clk),
    .rst_n   (rst_n),
    .a_valid (a_valid),
    .a_cd    (a_cd),
    .a_take  (a_take),
    .b_valid (b_valid),
    .b_word  (b_word),
    .b_stall (b_stall)
  );

  dks_pc2 u_pc2 (
    .clk             (clk),
    .rst_n           (rst_n),
    .b_valid         (b_valid),
    .b_word          (b_word),
    .b_stall         (b_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_subkey      (out_subkey),
    .out_round_index (out_round_index),
    .out_last_subkey (out_last_subkey)
  );

endmodule

`default_nettype wire
